/* rtl/core/lrukc_pkg.sv */
// Package for the keyed record cache: field widths, command codes and
// the sequencer state type. No dependencies.
`default_nettype none

package lrukc_pkg;

   localparam int CMD_W = 2;   // command field
   localparam int KEY_W = 31;  // document key
   localparam int REC_W = 64;  // record payload
   localparam int OCC_W = 7;   // occupancy field and capacity write data
   localparam int CNT_W = 32;  // hit and miss totals

   typedef enum logic [CMD_W-1:0] {
      CMD_GET   = 2'd0,
      CMD_PUT   = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_DATA
   } state_type;

endpackage

`default_nettype wire

/* rtl/core/lrukc_if.sv */
// Valid/ready channel interfaces for the keyed record cache requests and
// responses. Depends on lrukc_pkg.
`default_nettype none

interface lrukc_req_if;
   import lrukc_pkg::*;

   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [KEY_W-1:0] doc_key;
   logic [REC_W-1:0] record_in;

   modport source (output valid, command, doc_key, record_in, input ready);
   modport sink (input valid, command, doc_key, record_in, output ready);
endinterface

interface lrukc_rsp_if;
   import lrukc_pkg::*;

   logic             valid;
   logic             ready;
   logic             found;
   logic [REC_W-1:0] record_out;
   logic [OCC_W-1:0] occupancy;
   logic [CNT_W-1:0] hit_total;
   logic [CNT_W-1:0] miss_total;

   modport source (output valid, found, record_out, occupancy, hit_total, miss_total,
                   input ready);
   modport sink (input valid, found, record_out, occupancy, hit_total, miss_total,
                 output ready);
endinterface

`default_nettype wire

/* rtl/core/lrukc_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module lrukc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/lru_keyed_record_cache.sv */
// Fully associative record cache with least-recently-used replacement.
// Depends on lrukc_pkg, lrukc_if (request/response channels) and lrukc_ram.
//
// Usage:
//   Requests arrive on req_ch (command, doc_key, record_in); a transfer takes
//   place when valid and ready are both high. A get looks up the key, a put
//   updates or inserts a record, and a clear empties the cache and zeroes
//   both totals. Every request produces exactly one response transfer on
//   rsp_ch carrying found, record_out, occupancy and the hit and miss totals.
//   The capacity register is written through csr_wr_en / csr_wr_data while
//   the cache is idle; lowering it drops the oldest entries at once.
//
// Request flow:
//   A request passes through the key compare and age update in LOOK, then
//   through the record memory read in DATA, where its response is loaded
//   into the output register. A new request is taken in the same cycle the
//   previous response is loaded, so no request is accepted while the
//   previous one is still in LOOK or waiting in DATA.
//
// Reset clears all valid bits, age ranks, occupancy and both totals, sets
// capacity to ENTRIES and holds req_ch.ready low. The response is held in an
// output register: while the receiver stalls, one more request is still taken
// and processed until its response waits for the output register to free up.
`default_nettype none

module lru_keyed_record_cache #(
   parameter int ENTRIES = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   lrukc_req_if.sink                  req_ch,
   lrukc_rsp_if.source                rsp_ch,
   input  logic                       csr_wr_en,
   input  logic [lrukc_pkg::OCC_W-1:0] csr_wr_data
);

   import lrukc_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CAP_W = $clog2(ENTRIES + 1);

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // Sequencer.
   state_type state_ff, state_in;
   logic      req_ready;
   logic      look_active;
   logic      data_load;
   logic      out_can_load;

   // Request held for the lookup cycle.
   cmd_type          cmd_ff;
   logic [KEY_W-1:0] key_ff;
   logic [REC_W-1:0] rec_ff;

   // Per-entry tag state: keys, valid bits and age ranks in flip-flops.
   logic [KEY_W-1:0] keys_ff  [ENTRIES];
   logic [IDX_W-1:0] rank_ff  [ENTRIES];
   logic [IDX_W-1:0] rank_in  [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [ENTRIES-1:0] key_we;

   logic [CAP_W-1:0] count_ff, count_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [CNT_W-1:0] hits_ff, hits_in;
   logic [CNT_W-1:0] misses_ff, misses_in;

   // Lookup results.
   logic [ENTRIES-1:0] hit_vec;
   logic               hit_any;
   logic [IDX_W-1:0]   hit_idx;
   logic [IDX_W-1:0]   hit_rank;
   logic               full;
   logic [ENTRIES-1:0] evict_vec;
   logic [ENTRIES-1:0] keep_vec;
   logic [ENTRIES-1:0] free_onehot;
   logic               free_any;
   logic [IDX_W-1:0]   free_idx;
   logic [CAP_W-1:0]   count_base;

   // Capacity write decode.
   logic [31:0] csr_val32;
   logic [31:0] csr_sel32;

   // Flags carried from the lookup cycle to the data cycle.
   logic found_ff;
   logic get_hit_ff;

   // Record memory.
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic             ram_rd_en;
   logic [REC_W-1:0] ram_rd_data;

   // Output register.
   logic             rsp_valid_ff;
   logic             rsp_found_ff;
   logic [REC_W-1:0] rsp_record_ff;
   logic [OCC_W-1:0] rsp_occ_ff;
   logic [CNT_W-1:0] rsp_hits_ff;
   logic [CNT_W-1:0] rsp_misses_ff;
   logic [31:0]      count32;

   // ------------------------------------------------------------------
   // Sequencer: IDLE waits for a request, LOOK compares keys and updates
   // the tag state, DATA collects the memory read and loads the response.
   // A request can be taken in DATA as soon as the response is loaded.
   // ------------------------------------------------------------------
   assign out_can_load = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_DATA;
         end
         ST_DATA: begin
            if (out_can_load) begin
               state_in = req_ch.valid ? ST_LOOK : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      look_active = 1'b0;
      data_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // No request is taken while reset is held.
            req_ready = !reset;
         end
         ST_LOOK: begin
            look_active = 1'b1;
         end
         ST_DATA: begin
            data_load = out_can_load;
            req_ready = out_can_load;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign req_ch.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ready) begin
         cmd_ff <= cmd_type'(req_ch.command);
         key_ff <= req_ch.doc_key;
         rec_ff <= req_ch.record_in;
      end
   end

   // ------------------------------------------------------------------
   // Parallel key compare. Keys of valid entries are unique, so the hit
   // vector is one-hot and the index and rank can be ORed together.
   // ------------------------------------------------------------------
   always_comb begin
      hit_idx  = '0;
      hit_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i] = valid_ff[i] && (keys_ff[i] == key_ff);
         if (hit_vec[i]) begin
            hit_idx  = hit_idx | IDX_W'(i);
            hit_rank = hit_rank | rank_ff[i];
         end
      end
      hit_any = |hit_vec;
   end

   // When the cache is at capacity, an insert drops the entry whose rank is
   // capacity minus one, then takes the lowest free slot.
   assign full = (count_ff >= cap_ff);

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         evict_vec[i] = full && valid_ff[i] &&
                        (32'(rank_ff[i]) >= (32'(cap_ff) - 32'd1));
      end
   end

   assign keep_vec    = valid_ff & ~evict_vec;
   assign free_onehot = ~keep_vec & (keep_vec + ENTRIES'(1));
   assign free_any    = |free_onehot;
   assign count_base  = full ? (cap_ff - CAP_W'(1)) : count_ff;

   always_comb begin
      free_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (free_onehot[i]) begin
            free_idx = free_idx | IDX_W'(i);
         end
      end
   end

   // Capacity write: zero is ignored, values above ENTRIES saturate.
   assign csr_val32 = 32'(csr_wr_data);
   assign csr_sel32 = (csr_val32 > 32'(ENTRIES)) ? 32'(ENTRIES) : csr_val32;

   always_comb begin
      cap_in = cap_ff;
      if (csr_wr_en && (csr_val32 != 32'd0)) begin
         cap_in = csr_sel32[CAP_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Next tag state. A capacity write trims the oldest entries; otherwise
   // the lookup cycle applies the command.
   // ------------------------------------------------------------------
   always_comb begin
      valid_in  = valid_ff;
      rank_in   = rank_ff;
      count_in  = count_ff;
      key_we    = '0;
      hits_in   = hits_ff;
      misses_in = misses_ff;

      if (csr_wr_en) begin
         if (count_ff > cap_in) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i] && (32'(rank_ff[i]) >= 32'(cap_in))) begin
                  valid_in[i] = 1'b0;
                  rank_in[i]  = '0;
               end
            end
            count_in = cap_in;
         end
      end else if (look_active) begin
         case (cmd_ff)
            CMD_GET, CMD_PUT: begin
               if (hit_any) begin
                  // Promote: younger entries age by one, the hit becomes newest.
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                        rank_in[i] = rank_ff[i] + IDX_W'(1);
                     end
                     if (hit_vec[i]) begin
                        rank_in[i] = '0;
                     end
                  end
                  if (cmd_ff == CMD_GET && hits_ff != CNT_MAX) begin
                     hits_in = hits_ff + CNT_W'(1);
                  end
               end else if (cmd_ff == CMD_GET) begin
                  if (misses_ff != CNT_MAX) begin
                     misses_in = misses_ff + CNT_W'(1);
                  end
               end else begin
                  // Insert: every kept entry ages, the new one enters as newest.
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (keep_vec[i]) begin
                        rank_in[i] = rank_ff[i] + IDX_W'(1);
                     end else begin
                        rank_in[i] = '0;
                     end
                  end
                  valid_in = keep_vec | free_onehot;
                  key_we   = free_onehot;
                  count_in = count_base + CAP_W'(free_any);
               end
            end
            CMD_CLEAR: begin
               valid_in  = '0;
               for (int i = 0; i < ENTRIES; i++) begin
                  rank_in[i] = '0;
               end
               count_in  = '0;
               hits_in   = '0;
               misses_in = '0;
            end
            default: begin
               valid_in = valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         count_ff  <= '0;
         cap_ff    <= CAP_W'(ENTRIES);
         hits_ff   <= '0;
         misses_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff  <= valid_in;
         count_ff  <= count_in;
         cap_ff    <= cap_in;
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (key_we[i]) begin
            keys_ff[i] <= key_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (look_active) begin
         found_ff   <= hit_any && (cmd_ff == CMD_GET || cmd_ff == CMD_PUT);
         get_hit_ff <= hit_any && (cmd_ff == CMD_GET);
      end
   end

   // ------------------------------------------------------------------
   // Record memory: a put writes in the lookup cycle, a get hit reads and
   // the data is ready in the following cycle.
   // ------------------------------------------------------------------
   assign ram_wr_en   = look_active && (cmd_ff == CMD_PUT) && (hit_any || free_any);
   assign ram_wr_addr = hit_any ? hit_idx : free_idx;
   assign ram_rd_en   = look_active && (cmd_ff == CMD_GET) && hit_any;

   lrukc_ram #(
      .WIDTH (REC_W),
      .DEPTH (ENTRIES)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (rec_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (hit_idx),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------
   // Output register.
   // ------------------------------------------------------------------
   assign count32 = 32'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (data_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (data_load) begin
         rsp_found_ff  <= found_ff;
         rsp_record_ff <= get_hit_ff ? ram_rd_data : '0;
         rsp_occ_ff    <= count32[OCC_W-1:0];
         rsp_hits_ff   <= hits_ff;
         rsp_misses_ff <= misses_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.found      = rsp_found_ff;
   assign rsp_ch.record_out = rsp_record_ff;
   assign rsp_ch.occupancy  = rsp_occ_ff;
   assign rsp_ch.hit_total  = rsp_hits_ff;
   assign rsp_ch.miss_total = rsp_misses_ff;

endmodule

`default_nettype wire

/* rtl/core/lrukc_checker.sv */
// Port-level checks for the keyed record cache response channel, bound to
// the top level. Depends on lrukc_pkg and lru_keyed_record_cache.
`default_nettype none

module lrukc_checker #(
   parameter int ENTRIES = 64
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_found,
   input logic [lrukc_pkg::REC_W-1:0] rsp_record_out,
   input logic [lrukc_pkg::OCC_W-1:0] rsp_occupancy,
   input logic [lrukc_pkg::CNT_W-1:0] rsp_hit_total,
   input logic [lrukc_pkg::CNT_W-1:0] rsp_miss_total
);

   // The output register is emptied by reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response keeps its contents.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) &&
      $stable(rsp_record_out) && $stable(rsp_occupancy) &&
      $stable(rsp_hit_total) && $stable(rsp_miss_total))
      else $error("stalled response changed");

   // Occupancy never exceeds the number of entries.
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_occupancy) <= 32'(ENTRIES)))
      else $error("occupancy above entry count");

   // A record is returned only together with a hit.
   a_record_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_record_out == '0))
      else $error("record returned without a hit");

endmodule

bind lru_keyed_record_cache lrukc_checker #(
   .ENTRIES (ENTRIES)
) u_lrukc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_found      (rsp_ch.found),
   .rsp_record_out (rsp_ch.record_out),
   .rsp_occupancy  (rsp_ch.occupancy),
   .rsp_hit_total  (rsp_ch.hit_total),
   .rsp_miss_total (rsp_ch.miss_total)
);

`default_nettype wire

/* sim/tb_lru_keyed_record_cache.sv */
// Self-checking testbench for lru_keyed_record_cache: directed table plus random traffic.
// Depends on lrukc_pkg and the lrukc_req_if / lrukc_rsp_if interfaces from the RTL.
`timescale 1ns / 100ps

module tb_lru_keyed_record_cache;
   import lrukc_pkg::*;

   // Command code that the block must treat as a no-op.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int SLOTS = 64;

   // One response transfer, laid out in the order of the response fields.
   typedef struct packed {
      logic             found;
      logic [REC_W-1:0] record;
      logic [OCC_W-1:0] occupancy;
      logic [CNT_W-1:0] hits;
      logic [CNT_W-1:0] misses;
   } lookup_result_type;

   // One row of the directed script: either a capacity write or a request.
   // Rows marked known carry a hand-typed expected response.
   typedef struct {
      bit                is_csr;
      logic [OCC_W-1:0]  cap_value;
      logic [CMD_W-1:0]  cmd;
      logic [KEY_W-1:0]  key;
      logic [REC_W-1:0]  rec;
      bit                known;
      lookup_result_type want;
   } script_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [OCC_W-1:0] csr_wr_data;

   lrukc_req_if req_ch ();
   lrukc_rsp_if rsp_ch ();

   lru_keyed_record_cache dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 8 ns clock period.
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // The run is cut off if it hangs. A correct run needs well under a tenth
   // of this time even with the heaviest idling on both sides.
   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Cache shadow: an independent copy of the cache contents, the LRU ranks
   // and the totals. Rank 0 is the most recently used live entry; live ranks
   // always run from 0 to live_count-1.
   // ------------------------------------------------------------------------
   logic [KEY_W-1:0] shadow_keys [SLOTS];
   logic [REC_W-1:0] shadow_records [SLOTS];
   bit               shadow_live [SLOTS];
   int               shadow_rank [SLOTS];
   int               live_count;
   logic [CNT_W-1:0] hit_count;
   logic [CNT_W-1:0] miss_count;
   int               cap_limit;

   // Responses still owed by the block, oldest first.
   lookup_result_type pending_results [$];

   int send_idle_pct;
   int recv_idle_pct;
   int failures;
   int requests_sent;
   int results_seen;
   int found_results;
   int cap_writes;

   function automatic void shadow_clear();
      for (int i = 0; i < SLOTS; i++) begin
         shadow_live[i] = 1'b0;
         shadow_rank[i] = 0;
      end
      live_count = 0;
      hit_count  = '0;
      miss_count = '0;
   endfunction

   // Moves one entry to rank 0; the entries that were more recent age by one.
   function automatic void promote_slot(int slot);
      int old_rank;
      old_rank = shadow_rank[slot];
      for (int i = 0; i < SLOTS; i++) begin
         if (shadow_live[i] && shadow_rank[i] < old_rank) shadow_rank[i]++;
      end
      shadow_rank[slot] = 0;
   endfunction

   // Drops every live entry whose rank is at or beyond the limit, so the
   // oldest entries go first.
   function automatic void drop_oldest(int limit);
      if (live_count <= limit) return;
      for (int i = 0; i < SLOTS; i++) begin
         if (shadow_live[i] && shadow_rank[i] >= limit) begin
            shadow_live[i] = 1'b0;
            shadow_rank[i] = 0;
         end
      end
      live_count = limit;
   endfunction

   // A zero write is ignored; anything above the slot count saturates.
   function automatic void apply_capacity(logic [OCC_W-1:0] value);
      if (value == 0) return;
      cap_limit = (value > SLOTS) ? SLOTS : int'(value);
      drop_oldest(cap_limit);
   endfunction

   function automatic int find_slot(logic [KEY_W-1:0] key);
      for (int i = 0; i < SLOTS; i++) begin
         if (shadow_live[i] && shadow_keys[i] == key) return i;
      end
      return -1;
   endfunction

   // Applies one request to the shadow and returns the response it owes.
   function automatic lookup_result_type predict_access(logic [CMD_W-1:0] cmd,
                                                        logic [KEY_W-1:0] key,
                                                        logic [REC_W-1:0] rec);
      lookup_result_type res;
      int slot;
      int free_slot;
      res = '0;
      case (cmd)
         CMD_GET: begin
            slot = find_slot(key);
            if (slot >= 0) begin
               res.found  = 1'b1;
               res.record = shadow_records[slot];
               promote_slot(slot);
               if (hit_count != '1) hit_count++;
            end else if (miss_count != '1) begin
               miss_count++;
            end
         end
         CMD_PUT: begin
            slot = find_slot(key);
            if (slot >= 0) begin
               res.found = 1'b1;
               shadow_records[slot] = rec;
               promote_slot(slot);
            end else begin
               // Make room first, then age everyone and insert at rank 0.
               if (live_count >= cap_limit) drop_oldest(cap_limit - 1);
               for (int i = 0; i < SLOTS; i++) begin
                  if (shadow_live[i]) shadow_rank[i]++;
               end
               free_slot = -1;
               for (int i = SLOTS - 1; i >= 0; i--) begin
                  if (!shadow_live[i]) free_slot = i;
               end
               if (free_slot >= 0) begin
                  shadow_live[free_slot]    = 1'b1;
                  shadow_keys[free_slot]    = key;
                  shadow_records[free_slot] = rec;
                  shadow_rank[free_slot]    = 0;
                  live_count++;
               end
            end
         end
         CMD_CLEAR: shadow_clear();
         default: ;  // the unused code changes nothing
      endcase
      res.occupancy = live_count[OCC_W-1:0];
      res.hits      = hit_count;
      res.misses    = miss_count;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Request side. valid stays high across back-to-back transfers and is lowered
   // for a random idle gap before the next request, before a capacity write and
   // at the end of the run. The expected response is queued at the transfer edge.
   // ------------------------------------------------------------------------
   task automatic drive_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                logic [REC_W-1:0] rec, bit known = 1'b0,
                                lookup_result_type want = '0);
      int gap;
      lookup_result_type predicted;
      gap = 0;
      if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.command   <= cmd;
      req_ch.doc_key   <= key;
      req_ch.record_in <= rec;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = predict_access(cmd, key, rec);
      pending_results.push_back(known ? want : predicted);
      requests_sent++;
   endtask

   // The capacity register is only written once every owed response has
   // been taken, so the block is idle at the write.
   task automatic write_capacity(logic [OCC_W-1:0] value);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      apply_capacity(value);
      cap_writes++;
   endtask

   task automatic report_failure(string what, lookup_result_type want,
                                 lookup_result_type got);
      failures++;
      if (failures <= 10) begin
         $display("[%0t] %s", $realtime, what);
         $display("   expected found=%0b record=%h occupancy=%0d hits=%0d misses=%0d",
                  want.found, want.record, want.occupancy, want.hits, want.misses);
         $display("   actual   found=%0b record=%h occupancy=%0d hits=%0d misses=%0d",
                  got.found, got.record, got.occupancy, got.hits, got.misses);
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side: checks every transfer against the oldest expectation and
   // stalls the output at random according to recv_idle_pct.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : response_check
      lookup_result_type got;
      lookup_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.found, rsp_ch.record_out, rsp_ch.occupancy,
                   rsp_ch.hit_total, rsp_ch.miss_total};
            results_seen++;
            if (got.found) found_results++;
            if (pending_results.size() == 0) begin
               report_failure("response with no request outstanding", '0, got);
            end else begin
               want = pending_results.pop_front();
               if (got.found !== want.found || got.record !== want.record ||
                   got.occupancy !== want.occupancy || got.hits !== want.hits ||
                   got.misses !== want.misses) begin
                  report_failure("response mismatch", want, got);
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Directed script helpers.
   // ------------------------------------------------------------------------
   script_row_type directed_script [$];

   function automatic void add_csr(logic [OCC_W-1:0] value);
      script_row_type row;
      row = '{default: '0};
      row.is_csr    = 1'b1;
      row.cap_value = value;
      directed_script.push_back(row);
   endfunction

   function automatic void add_op(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                  logic [REC_W-1:0] rec);
      script_row_type row;
      row = '{default: '0};
      row.cmd = cmd;
      row.key = key;
      row.rec = rec;
      directed_script.push_back(row);
   endfunction

   function automatic void add_known(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                     logic [REC_W-1:0] rec, logic found,
                                     logic [REC_W-1:0] record, int occ, int hits,
                                     int misses);
      script_row_type row;
      row = '{default: '0};
      row.cmd   = cmd;
      row.key   = key;
      row.rec   = rec;
      row.known = 1'b1;
      row.want  = {found, record, OCC_W'(occ), CNT_W'(hits), CNT_W'(misses)};
      directed_script.push_back(row);
   endfunction

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   initial begin : main_sequence
      logic [KEY_W-1:0] key_pool [$];
      logic [KEY_W-1:0] key;
      logic [OCC_W-1:0] cap_choice;
      logic [CMD_W-1:0] cmd;
      int pool_size;
      int put_pct;
      int pick;

      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.command   <= CMD_GET;
      req_ch.doc_key   <= '0;
      req_ch.record_in <= '0;

      failures      = 0;
      requests_sent = 0;
      results_seen  = 0;
      found_results = 0;
      cap_writes    = 0;
      shadow_clear();
      cap_limit     = SLOTS;
      send_idle_pct = 36;
      recv_idle_pct = 74;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The first rows start from the empty cache and have
      // their responses typed in; they cover both key extremes, an all-ones
      // and an all-zero record, a put that updates, the unused command and
      // a clear. The later rows shrink capacity below occupancy, write zero
      // (ignored), write one, and write above the slot count (saturates).
      add_known(CMD_GET,    '0, '0, 0, '0, 0, 0, 1);
      add_known(CMD_PUT,    '0, '0, 0, '0, 1, 0, 1);
      add_known(CMD_PUT,    '1, '1, 0, '0, 2, 0, 1);
      add_known(CMD_GET,    '1, '0, 1, '1, 2, 1, 1);
      add_known(CMD_GET,    '0, '1, 1, '0, 2, 2, 1);
      add_known(CMD_PUT,    '0, 64'hA5A5_A5A5_5A5A_5A5A, 1, '0, 2, 2, 1);
      add_known(CMD_GET,    '0, '0, 1, 64'hA5A5_A5A5_5A5A_5A5A, 2, 3, 1);
      add_known(CMD_UNUSED, '1, '1, 0, '0, 2, 3, 1);
      add_known(CMD_GET,    31'd5, '0, 0, '0, 2, 3, 2);
      add_known(CMD_CLEAR,  '1, '1, 0, '0, 0, 0, 0);
      add_known(CMD_GET,    '1, '0, 0, '0, 0, 0, 1);
      add_op(CMD_PUT, 31'd1, 64'h1111);
      add_op(CMD_PUT, 31'd2, 64'h2222);
      add_op(CMD_PUT, 31'd3, 64'h3333);
      add_csr(7'd2);
      add_op(CMD_GET, 31'd1, '0);
      add_op(CMD_PUT, 31'd4, 64'h4444);
      add_op(CMD_GET, 31'd2, '0);
      add_csr(7'd0);
      add_op(CMD_GET, 31'd3, '0);
      add_csr(7'd1);
      add_op(CMD_PUT, 31'd5, 64'h5555);
      add_op(CMD_GET, 31'd5, '0);
      add_op(CMD_GET, 31'd3, '0);
      add_csr(7'd127);
      add_op(CMD_PUT, 31'd6, 64'h6666);
      add_op(CMD_GET, 31'd6, '0);
      add_op(CMD_GET, 31'd5, '0);

      foreach (directed_script[i]) begin
         if (directed_script[i].is_csr) begin
            write_capacity(directed_script[i].cap_value);
         end else begin
            drive_request(directed_script[i].cmd, directed_script[i].key,
                          directed_script[i].rec, directed_script[i].known,
                          directed_script[i].want);
         end
      end

      // Random part, in three idling modes. Each mode runs four capacity
      // settings: a small one, the full size, one, and a random write that
      // may be zero or above the slot count. Keys mostly come from a pool a
      // little larger than the capacity so that hits, updates and evictions
      // all happen; for large capacities the pool is first filled by puts so
      // that the replacement path is reached at the full size too.
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin send_idle_pct = 36; recv_idle_pct = 74; end
            1: begin send_idle_pct = 74; recv_idle_pct = 36; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int phase = 0; phase < 4; phase++) begin
            case (phase)
               0: cap_choice = OCC_W'($urandom_range(2, 8));
               1: cap_choice = OCC_W'(SLOTS);
               2: cap_choice = 7'd1;
               default: cap_choice = OCC_W'($urandom_range(0, 127));
            endcase
            write_capacity(cap_choice);

            pool_size = cap_limit + 4;
            key_pool.delete();
            repeat (pool_size) key_pool.push_back(KEY_W'($urandom));

            if (cap_limit >= 32) begin
               foreach (key_pool[k]) drive_request(CMD_PUT, key_pool[k], {$urandom, $urandom});
            end
            put_pct = (cap_limit >= 32) ? 40 : 50;

            repeat (cap_limit >= 32 ? 20 : 16) begin
               pick = $urandom_range(99);
               if (pick < 2)                  cmd = CMD_CLEAR;
               else if (pick < 4)             cmd = CMD_UNUSED;
               else if (pick < 100 - put_pct) cmd = CMD_GET;
               else                           cmd = CMD_PUT;
               if ($urandom_range(99) < 90) key = key_pool[$urandom_range(0, pool_size - 1)];
               else                         key = KEY_W'($urandom);
               drive_request(cmd, key, {$urandom, $urandom});
            end
         end
      end

      // Drain: once every owed response has been taken, a short extra wait is
      // enough to catch any response nobody asked for.
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (pending_results.size() != 0) failures++;
      $display("Run covered %0d requests and %0d responses (%0d with a key found).",
               requests_sent, results_seen, found_results);
      $display("Capacity was written %0d times under three idling modes; %0d failures.",
               cap_writes, failures);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
